/* rtl/qte_pkg.sv */
// Shared constants, types and the arctangent table for the quaternion to Euler converter.
// No dependencies.
package qte_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_LEN      = 24;
   localparam int CORDIC_STEPS  = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

   localparam int QW    = 16;          // quaternion component
   localparam int PW    = 2 * QW;      // component product
   localparam int TW    = 34;          // doubled sum of products
   localparam int CW    = 36;          // CORDIC vector datapath
   localparam int ZW    = 33;          // CORDIC angle, centidegrees * 2^16
   localparam int AW    = 16;          // roll/yaw angle
   localparam int PAW   = 15;          // pitch angle
   localparam int SINW  = 29;          // unsaturated pitch sine term
   localparam int MAGW  = 28;          // magnitude of pitch sine term
   localparam int SQW   = 2 * MAGW;    // its square
   localparam int VW    = 58;          // square root remainder / root register
   localparam int ROOTW = 29;          // square root result
   localparam int SQRT_STEPS = 29;     // one result bit per step
   localparam int SQRT_LAT   = SQRT_STEPS + 2;
   localparam int CORD_LAT   = CORDIC_STEPS + 2;

   localparam logic signed [TW-1:0] ONE_Q28     = 34'sd268435456;
   localparam logic signed [TW-1:0] NEG_ONE_Q28 = -34'sd268435456;
   localparam logic signed [ZW-1:0] HALF_TURN   = 33'sd1179648000;
   localparam logic signed [ZW:0]   ROUND_HALF  = 34'sd32768;
   localparam logic signed [AW-1:0] ANGLE_MAX   = 16'sd18000;
   localparam logic signed [AW-1:0] PITCH_MAX   = 16'sd9000;

   // Stage B output of the front end
   typedef struct packed {
      logic signed [TW-1:0]   roll_sin;
      logic signed [TW-1:0]   roll_cos;
      logic signed [TW-1:0]   yaw_sin;
      logic signed [TW-1:0]   yaw_cos;
      logic signed [SINW-1:0] pitch_sin;
      logic [MAGW-1:0]        pitch_mag;
      logic                   sat_pos;
      logic                   sat_neg;
   } terms_type;

   // Pitch side information carried along the square root
   typedef struct packed {
      logic signed [SINW-1:0] pitch_sin;
      logic                   sat_pos;
      logic                   sat_neg;
   } pitch_side_type;

   // Result payload, roll in the low bits
   typedef struct packed {
      logic                   pad;
      logic signed [AW-1:0]   yaw;
      logic signed [PAW-1:0]  pitch;
      logic signed [AW-1:0]   roll;
   } result_type;

   // atan(2^-i) in centidegrees * 2^16, rounded
   function automatic logic signed [ZW-1:0] atan_entry(input int idx);
      logic signed [ZW-1:0] val;
      case (idx)
         0:  val = 33'sd294912000;
         1:  val = 33'sd174096719;
         2:  val = 33'sd91987925;
         3:  val = 33'sd46694507;
         4:  val = 33'sd23437865;
         5:  val = 33'sd11730358;
         6:  val = 33'sd5866610;
         7:  val = 33'sd2933484;
         8:  val = 33'sd1466764;
         9:  val = 33'sd733385;
         10: val = 33'sd366693;
         11: val = 33'sd183346;
         12: val = 33'sd91673;
         13: val = 33'sd45837;
         14: val = 33'sd22918;
         15: val = 33'sd11459;
         16: val = 33'sd5730;
         17: val = 33'sd2865;
         18: val = 33'sd1432;
         19: val = 33'sd716;
         20: val = 33'sd358;
         21: val = 33'sd179;
         22: val = 33'sd90;
         23: val = 33'sd45;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

/* rtl/quaternion_to_euler_angles.sv */
// Quaternion (w, x, y, z, signed Q1.14) to Z-Y-X Euler angles in signed centidegrees:
// roll = atan2(2(wx+yz), 1-2(xx+yy)), pitch = asin(2(wy-zx)), yaw = atan2(2(wz+xy), 1-2(yy+zz)).
// One request is accepted per cycle while the skid register is empty, and one result comes out
// per cycle while rsp_tready is high, in order. The pitch path sets the timing: the exact square
// root for the pitch cosine (one root bit per stage, 29 stages plus square and subtract) followed
// by the arctangent CORDIC. Roll and yaw run their CORDICs early and wait in a delay line. When
// |2(wy-zx)| reaches 1.0, pitch is forced to +/-9000 and tuser[0] is set.
// A skid register behind the output register keeps req_tready high for one result while
// rsp_tready is low; the whole pipeline holds only while the skid register is occupied.
// Depends on qte_pkg, qte_prep, qte_isqrt and qte_cordic.
module quaternion_to_euler_angles
   import qte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // roll[15:0], pitch[30:16], yaw[46:31], zero[47]
   output logic [0:0]  rsp_tuser    // pitch_saturated[0]
);

   logic                   en;
   logic                   terms_valid;
   terms_type              terms;
   logic                   root_valid;
   logic [ROOTW-1:0]       root;
   pitch_side_type         side_in, side_out;
   logic signed [AW-1:0]   roll_ang, yaw_ang, pitch_ang;
   logic                   roll_valid, yaw_valid;
   logic                   fin_valid;
   result_type             fin_data;
   logic                   fin_sat;

   logic signed [AW-1:0]   roll_dly_ff [SQRT_LAT];
   logic signed [AW-1:0]   yaw_dly_ff  [SQRT_LAT];
   logic                   satp_dly_ff [CORD_LAT];
   logic                   satn_dly_ff [CORD_LAT];

   result_type             out_data_ff, skid_data_ff;
   logic                   out_sat_ff, skid_sat_ff;
   logic                   out_valid_ff, skid_valid_ff;
   logic                   out_take;

   // pipeline advances whenever the skid register is free
   assign en         = !skid_valid_ff;
   assign req_tready = en;

   qte_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .quat_w    (req_tdata[15:0]),
      .quat_x    (req_tdata[31:16]),
      .quat_y    (req_tdata[47:32]),
      .quat_z    (req_tdata[63:48]),
      .out_valid (terms_valid),
      .terms     (terms)
   );

   qte_cordic u_roll (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (terms_valid),
      .vec_y     (CW'(terms.roll_sin)),
      .vec_x     (CW'(terms.roll_cos)),
      .out_valid (roll_valid),
      .angle     (roll_ang)
   );

   qte_cordic u_yaw (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (terms_valid),
      .vec_y     (CW'(terms.yaw_sin)),
      .vec_x     (CW'(terms.yaw_cos)),
      .out_valid (yaw_valid),
      .angle     (yaw_ang)
   );

   assign side_in.pitch_sin = terms.pitch_sin;
   assign side_in.sat_pos   = terms.sat_pos;
   assign side_in.sat_neg   = terms.sat_neg;

   qte_isqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (terms_valid),
      .mag       (terms.pitch_mag),
      .side_i    (side_in),
      .out_valid (root_valid),
      .root      (root),
      .side_o    (side_out)
   );

   qte_cordic u_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (root_valid),
      .vec_y     (CW'(side_out.pitch_sin)),
      .vec_x     (signed'(CW'(root))),
      .out_valid (fin_valid),
      .angle     (pitch_ang)
   );

   // roll/yaw wait for the square root; saturation flags wait for the pitch CORDIC
   always_ff @(posedge clock) begin
      if (en) begin
         roll_dly_ff[0] <= roll_ang;
         yaw_dly_ff[0]  <= yaw_ang;
         for (int i = 1; i < SQRT_LAT; i++) begin
            roll_dly_ff[i] <= roll_dly_ff[i-1];
            yaw_dly_ff[i]  <= yaw_dly_ff[i-1];
         end
         satp_dly_ff[0] <= side_out.sat_pos;
         satn_dly_ff[0] <= side_out.sat_neg;
         for (int i = 1; i < CORD_LAT; i++) begin
            satp_dly_ff[i] <= satp_dly_ff[i-1];
            satn_dly_ff[i] <= satn_dly_ff[i-1];
         end
      end
   end

   // final pitch: clamp to +/-90 degrees, or force it when the sine term saturated
   always_comb begin
      fin_data.pad  = 1'b0;
      fin_data.roll = roll_dly_ff[SQRT_LAT-1];
      fin_data.yaw  = yaw_dly_ff[SQRT_LAT-1];
      fin_sat       = satp_dly_ff[CORD_LAT-1] || satn_dly_ff[CORD_LAT-1];
      if (satp_dly_ff[CORD_LAT-1]) begin
         fin_data.pitch = PITCH_MAX[PAW-1:0];
      end else if (satn_dly_ff[CORD_LAT-1]) begin
         fin_data.pitch = PAW'(-PITCH_MAX);
      end else if (pitch_ang > PITCH_MAX) begin
         fin_data.pitch = PITCH_MAX[PAW-1:0];
      end else if (pitch_ang < -PITCH_MAX) begin
         fin_data.pitch = PAW'(-PITCH_MAX);
      end else begin
         fin_data.pitch = pitch_ang[PAW-1:0];
      end
   end

   // output register with skid
   assign out_take = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (fin_valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_ff <= skid_data_ff;
            out_sat_ff  <= skid_sat_ff;
         end
      end else if (fin_valid) begin
         if (!out_valid_ff || out_take) begin
            out_data_ff <= fin_data;
            out_sat_ff  <= fin_sat;
         end else begin
            skid_data_ff <= fin_data;
            skid_sat_ff  <= fin_sat;
         end
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tuser[0] = out_sat_ff;

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while output is empty");

   a_sat_pitch: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         ((rsp_tdata[30:16] == 15'd9000) || (rsp_tdata[30:16] == 15'(-9000))))
      else $error("saturated pitch not at +/-90 degrees");

   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready && !skid_valid_ff && fin_valid) |=> skid_valid_ff)
      else $error("result reaching a stalled output was not caught by the skid register");

   a_roll_yaw_lockstep: assert property (@(posedge clock) disable iff (reset)
      roll_valid == yaw_valid)
      else $error("roll and yaw CORDICs out of step");
`endif

endmodule

/* rtl/qte_prep.sv */
// Front end: component products, then the doubled sine/cosine terms and pitch saturation.
// Depends on qte_pkg.
module qte_prep
   import qte_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [QW-1:0] quat_w,
   input  logic signed [QW-1:0] quat_x,
   input  logic signed [QW-1:0] quat_y,
   input  logic signed [QW-1:0] quat_z,
   output logic                 out_valid,
   output terms_type            terms
);

   logic                 a_valid_ff, b_valid_ff;
   logic signed [PW-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;
   terms_type            terms_ff, terms_in;
   logic signed [TW-1:0] sp_abs;

   always_comb begin
      terms_in.roll_sin = (TW'(wx_ff) + TW'(yz_ff)) <<< 1;
      terms_in.roll_cos = ONE_Q28 - ((TW'(xx_ff) + TW'(yy_ff)) <<< 1);
      terms_in.yaw_sin  = (TW'(wz_ff) + TW'(xy_ff)) <<< 1;
      terms_in.yaw_cos  = ONE_Q28 - ((TW'(yy_ff) + TW'(zz_ff)) <<< 1);
      sp_abs            = (TW'(wy_ff) - TW'(zx_ff)) <<< 1;
      terms_in.pitch_sin = sp_abs[SINW-1:0];
      terms_in.sat_pos   = sp_abs >= ONE_Q28;
      terms_in.sat_neg   = sp_abs <= NEG_ONE_Q28;
      if (sp_abs < 0) begin
         sp_abs = -sp_abs;
      end
      terms_in.pitch_mag = (terms_in.sat_pos || terms_in.sat_neg) ? '0 : sp_abs[MAGW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
      if (en) begin
         wx_ff    <= quat_w * quat_x;
         yz_ff    <= quat_y * quat_z;
         xx_ff    <= quat_x * quat_x;
         yy_ff    <= quat_y * quat_y;
         wy_ff    <= quat_w * quat_y;
         zx_ff    <= quat_z * quat_x;
         wz_ff    <= quat_w * quat_z;
         xy_ff    <= quat_x * quat_y;
         zz_ff    <= quat_z * quat_z;
         terms_ff <= terms_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign terms     = terms_ff;

endmodule

/* rtl/qte_isqrt.sv */
// Pipelined cosine of pitch: sqrt(1 - s*s), one root bit per stage, exact integer root.
// Depends on qte_pkg.
module qte_isqrt
   import qte_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [MAGW-1:0]  mag,
   input  pitch_side_type   side_i,
   output logic             out_valid,
   output logic [ROOTW-1:0] root,
   output pitch_side_type   side_o
);

   logic                 sq_valid_ff;
   logic [SQW-1:0]       sq_ff;
   pitch_side_type       sq_side_ff;

   logic                 valid_ff [SQRT_STEPS+1];
   logic [VW-1:0]        rem_ff   [SQRT_STEPS+1];
   logic [VW-1:0]        res_ff   [SQRT_STEPS+1];
   pitch_side_type       side_ff  [SQRT_STEPS+1];
   logic [VW-1:0]        rem_in   [SQRT_STEPS+1];
   logic [VW-1:0]        res_in   [SQRT_STEPS+1];

   // first step: 2^56 - s^2
   assign rem_in[0] = (VW'(1) << SQW) - VW'(sq_ff);
   assign res_in[0] = '0;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [VW-1:0] BIT = VW'(1) << (2 * (SQRT_STEPS - 1 - k));
      logic [VW:0] trial;
      logic        take;
      always_comb begin
         trial = {1'b0, res_ff[k]} + {1'b0, BIT};
         take  = {1'b0, rem_ff[k]} >= trial;
         rem_in[k+1] = take ? (rem_ff[k] - trial[VW-1:0]) : rem_ff[k];
         res_in[k+1] = take ? ((res_ff[k] >> 1) + BIT) : (res_ff[k] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         for (int k = 0; k <= SQRT_STEPS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         sq_valid_ff <= in_valid;
         valid_ff[0] <= sq_valid_ff;
         for (int k = 1; k <= SQRT_STEPS; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
      if (en) begin
         sq_ff      <= mag * mag;
         sq_side_ff <= side_i;
         side_ff[0] <= sq_side_ff;
         for (int k = 0; k <= SQRT_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            res_ff[k] <= res_in[k];
         end
         for (int k = 1; k <= SQRT_STEPS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS];
   assign root      = res_ff[SQRT_STEPS][ROOTW-1:0];
   assign side_o    = side_ff[SQRT_STEPS];

endmodule

/* rtl/qte_cordic.sv */
// Pipelined vectoring CORDIC: atan2(y, x) in centidegrees, rounded and clamped to +/-180 degrees.
// Depends on qte_pkg.
module qte_cordic
   import qte_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [CW-1:0] vec_y,
   input  logic signed [CW-1:0] vec_x,
   output logic                 out_valid,
   output logic signed [AW-1:0] angle
);

   logic                 valid_ff [CORDIC_STEPS+1];
   logic                 zero_ff  [CORDIC_STEPS+1];
   logic signed [CW-1:0] x_ff     [CORDIC_STEPS+1];
   logic signed [CW-1:0] y_ff     [CORDIC_STEPS+1];
   logic signed [ZW-1:0] z_ff     [CORDIC_STEPS+1];
   logic signed [CW-1:0] x_in     [CORDIC_STEPS+1];
   logic signed [CW-1:0] y_in     [CORDIC_STEPS+1];
   logic signed [ZW-1:0] z_in     [CORDIC_STEPS+1];
   logic                 out_valid_ff;
   logic signed [AW-1:0] angle_ff, angle_in;
   logic signed [ZW:0]   rounded;
   logic signed [ZW-16:0] whole;

   // left half plane: fold over and start from +/-180
   always_comb begin
      if (vec_x < 0) begin
         x_in[0] = -vec_x;
         y_in[0] = -vec_y;
         z_in[0] = (vec_y >= 0) ? HALF_TURN : -HALF_TURN;
      end else begin
         x_in[0] = vec_x;
         y_in[0] = vec_y;
         z_in[0] = '0;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      always_comb begin
         if (y_ff[i] >= 0) begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + atan_entry(i);
         end else begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - atan_entry(i);
         end
      end
   end

   always_comb begin
      rounded = (ZW+1)'(z_ff[CORDIC_STEPS]) + ROUND_HALF;
      whole   = rounded[ZW:16];
      if (zero_ff[CORDIC_STEPS]) begin
         angle_in = '0;
      end else if (whole > (ZW-15)'(ANGLE_MAX)) begin
         angle_in = ANGLE_MAX;
      end else if (whole < -(ZW-15)'(ANGLE_MAX)) begin
         angle_in = -ANGLE_MAX;
      end else begin
         angle_in = whole[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int i = 0; i <= CORDIC_STEPS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i <= CORDIC_STEPS; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
         out_valid_ff <= valid_ff[CORDIC_STEPS];
      end
      if (en) begin
         zero_ff[0] <= (vec_x == 0) && (vec_y == 0);
         for (int i = 1; i <= CORDIC_STEPS; i++) begin
            zero_ff[i] <= zero_ff[i-1];
         end
         for (int i = 0; i <= CORDIC_STEPS; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
         end
         angle_ff <= angle_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign angle     = angle_ff;

endmodule

/* test/tb_quaternion_to_euler_angles.sv */
// Testbench for quaternion_to_euler_angles: directed table plus random quaternions,
// checked against a bit-exact CORDIC predictor. Depends on qte_pkg and the DUT.
module tb_quaternion_to_euler_angles;
   import qte_pkg::*;

   localparam int LATENCY     = 52;
   localparam int N_RANDOM    = 830;
   localparam int CYCLE_LIMIT = 400000;
   localparam longint HALF_TURN_S = 64'sd18000 * 65536;
   localparam longint ONE_S       = 64'sd1 << 28;

   typedef struct {
      logic signed [15:0] w, x, y, z;
   } quat_type;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
      logic               sat;
   } angles_type;

   // directed row; chk = 1 when expected angles are typed in
   typedef struct {
      quat_type   q;
      bit         chk;
      angles_type a;
   } row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;    // w[15:0], x[31:16], y[47:32], z[63:48]
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;         // roll[15:0], pitch[30:16], yaw[46:31], zero[47]
   logic [0:0]  rsp_tuser;         // pitch_saturated[0]

   angles_type angles_pending[$];
   int      errors = 0;
   int      table_errors = 0;
   int      n_sent = 0, n_recv = 0, n_sat = 0;
   int      cycles = 0;
   bit      stim_done = 0;
   bit      hold_off = 0;

   quaternion_to_euler_angles uut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout at cycle %0d", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic longint asr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned res = 0, b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else res >>= 1;
         b >>= 2;
      end
      return longint'(res);
   endfunction

   // vectoring CORDIC, result in centidegrees rounded half up
   function automatic longint atan2_cdeg(longint sy, longint cx);
      longint acc = 0, nx, ny;
      if (cx == 0 && sy == 0) return 0;
      if (cx < 0) begin
         acc = (sy >= 0) ? HALF_TURN_S : -HALF_TURN_S;
         cx = -cx;
         sy = -sy;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (sy >= 0) begin
            nx = cx + asr(sy, i); ny = sy - asr(cx, i); acc += longint'(atan_entry(i));
         end else begin
            nx = cx - asr(sy, i); ny = sy + asr(cx, i); acc -= longint'(atan_entry(i));
         end
         cx = nx;
         sy = ny;
      end
      return asr(acc + 32768, 16);
   endfunction

   function automatic longint clip(longint v, longint lim);
      return (v > lim) ? lim : (v < -lim) ? -lim : v;
   endfunction

   function automatic angles_type euler_of(quat_type q);
      longint w = q.w, x = q.x, y = q.y, z = q.z;
      longint sp, mag;
      angles_type a;
      a.roll = 16'(clip(atan2_cdeg(2 * (w * x + y * z), ONE_S - 2 * (x * x + y * y)), 18000));
      a.yaw  = 16'(clip(atan2_cdeg(2 * (w * z + x * y), ONE_S - 2 * (y * y + z * z)), 18000));
      sp = 2 * (w * y - z * x);
      a.sat = 0;
      if (sp >= ONE_S) begin
         a.pitch = 15'(9000); a.sat = 1;
      end else if (sp <= -ONE_S) begin
         a.pitch = -15'sd9000; a.sat = 1;
      end else begin
         mag = (sp < 0) ? -sp : sp;
         a.pitch = 15'(clip(atan2_cdeg(sp, int_sqrt((64'd1 << 56) - mag * mag)), 9000));
      end
      return a;
   endfunction

   function automatic quat_type mk(int w, int x, int y, int z);
      quat_type q;
      q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
      return q;
   endfunction

   function automatic angles_type ang(int r, int p, int yw, bit s);
      angles_type a;
      a.roll = 16'(r); a.pitch = 15'(p); a.yaw = 16'(yw); a.sat = s;
      return a;
   endfunction

   function automatic int rnd_comp();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, 65535) - 32768;   // any bit pattern
         1:       return ($urandom_range(0, 1) ? 16384 : -16384);
         2:       return 0;
         default: return $urandom_range(0, 32768) - 16384;
      endcase
   endfunction

   // random quaternion, mostly near unit norm
   function automatic quat_type rnd_quat();
      real a, b, c, d, n;
      if ($urandom_range(0, 3) == 0)
         return mk(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
      a = $urandom_range(0, 2000) - 1000.0; b = $urandom_range(0, 2000) - 1000.0;
      c = $urandom_range(0, 2000) - 1000.0; d = $urandom_range(0, 2000) - 1000.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) return mk(16384, 0, 0, 0);
      return mk(int'(a / n * 16384), int'(b / n * 16384), int'(c / n * 16384),
                int'(d / n * 16384));
   endfunction

   // valid drops only for an idle gap, so zero gaps give back-to-back requests
   task automatic send(quat_type q);
      int gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      angles_pending.push_back(euler_of(q));
      req_tvalid <= 1;
      req_tdata  <= {q.z, q.y, q.x, q.w};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_sent++;
   endtask

   // sender: keep valid high back to back when gap is zero
   task automatic send_direct(quat_type q);
      send(q);
   endtask

   row_type rows[$];

   initial begin
      angles_type exp_a;
      // identity, gimbal lock, half turns, extremes
      rows.push_back('{mk(16384, 0, 0, 0), 1, ang(0, 0, 0, 0)});
      rows.push_back('{mk(0, 0, 0, 0), 1, ang(0, 0, 0, 0)});
      rows.push_back('{mk(11585, 0, 11585, 0), 0, ang(0, 0, 0, 0)});
      rows.push_back('{mk(16384, 0, 16384, 0), 1, ang(18000, 9000, 18000, 1)});
      rows.push_back('{mk(16384, 0, -16384, 0), 1, ang(18000, -9000, 18000, 1)});
      rows.push_back('{mk(0, 16384, 0, 0), 1, ang(18000, 0, 0, 0)});
      rows.push_back('{mk(0, 0, 0, 16384), 1, ang(0, 0, 18000, 0)});
      rows.push_back('{mk(0, -16384, 0, 0), 1, ang(18000, 0, 0, 0)});
      rows.push_back('{mk(0, 0, 16384, 0), 0, ang(0, 0, 0, 0)});
      rows.push_back('{mk(11585, 11585, 0, 0), 0, ang(0, 0, 0, 0)});
      rows.push_back('{mk(11585, -11585, 0, 0), 0, ang(0, 0, 0, 0)});
      rows.push_back('{mk(11585, 0, 0, -11585), 0, ang(0, 0, 0, 0)});
      rows.push_back('{mk(-32768, -32768, -32768, -32768), 0, ang(0, 0, 0, 0)});
      rows.push_back('{mk(32767, 32767, 32767, 32767), 0, ang(0, 0, 0, 0)});
      rows.push_back('{mk(-32768, 32767, -32768, 32767), 0, ang(0, 0, 0, 0)});
      rows.push_back('{mk(-16384, -16384, 16384, -16384), 0, ang(0, 0, 0, 0)});
      rows.push_back('{mk(8192, 8192, 8192, 8192), 0, ang(0, 0, 0, 0)});
      rows.push_back('{mk(8192, -8192, 8192, -8192), 0, ang(0, 0, 0, 0)});
      rows.push_back('{mk(1, 0, 0, 0), 0, ang(0, 0, 0, 0)});
      rows.push_back('{mk(0, 1, 1, 0), 0, ang(0, 0, 0, 0)});
      rows.push_back('{mk(16000, 100, 3000, -2000), 0, ang(0, 0, 0, 0)});

      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (rows[i]) begin
         // typed-in rows must agree with the predictor too
         exp_a = euler_of(rows[i].q);
         if (rows[i].chk && exp_a != rows[i].a) begin
            $display("%0t: table row %0d expected r=%0d p=%0d y=%0d s=%0d,", $time, i,
                     rows[i].a.roll, rows[i].a.pitch, rows[i].a.yaw, rows[i].a.sat);
            $display("   predicted r=%0d p=%0d y=%0d s=%0d",
                     exp_a.roll, exp_a.pitch, exp_a.yaw, exp_a.sat);
            table_errors++;
         end
         send_direct(rows[i].q);
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 200) hold_off = 1;   // receiver parks while we keep offering
         send(rnd_quat());
      end
      req_tvalid <= 0;
      stim_done = 1;
   end

   // receiver: random stalls, and one long hold-off to fill the pipeline
   initial begin
      int stall;
      bit held;
      held = 0;
      rsp_tready <= 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off && !held) begin
            held = 1;
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
         end
         stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
         if (stall != 0) begin
            rsp_tready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1;
      end
   end

   // result check
   always @(posedge clock) begin
      angles_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.roll  = rsp_tdata[15:0];
         got.pitch = rsp_tdata[30:16];
         got.yaw   = rsp_tdata[46:31];
         got.sat   = rsp_tuser[0];
         n_recv++;
         if (got.sat) n_sat++;
         if (angles_pending.size() == 0) begin
            $display("%0t: unexpected result r=%0d p=%0d y=%0d s=%0d", $time,
                     got.roll, got.pitch, got.yaw, got.sat);
            errors++;
         end else begin
            want = angles_pending.pop_front();
            if (got.roll !== want.roll) begin
               $display("%0t: roll expected %0d actual %0d", $time, want.roll, got.roll);
               errors++;
            end
            if (got.pitch !== want.pitch) begin
               $display("%0t: pitch expected %0d actual %0d", $time, want.pitch, got.pitch);
               errors++;
            end
            if (got.yaw !== want.yaw) begin
               $display("%0t: yaw expected %0d actual %0d", $time, want.yaw, got.yaw);
               errors++;
            end
            if (got.sat !== want.sat) begin
               $display("%0t: saturation expected %0d actual %0d", $time, want.sat, got.sat);
               errors++;
            end
            if (rsp_tdata[47] !== 1'b0) begin
               $display("%0t: pad bit expected 0 actual %b", $time, rsp_tdata[47]);
               errors++;
            end
         end
      end
   end

   // end of run
   initial begin
      int missing;
      wait (stim_done);
      wait (angles_pending.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      missing = angles_pending.size();
      if (missing != 0) begin
         $display("%0t: %0d results never arrived", $time, missing);
      end
      $display("Sent %0d quaternions, checked %0d results, %0d with pitch clamped",
               n_sent, n_recv, n_sat);
      if (errors == 0 && table_errors == 0 && missing == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
